// ===== hw/rtl/iocu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocu_pkg
// shared types, codes and constants of the on/off cycler
// ----------------------------------------------------------------------------
package iocu_pkg;

    localparam int TIME_BITS = 32;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int PCT_W     = 7;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int ELAP_W    = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;
    localparam int PROD_W    = DATA_W + PCT_W;
    localparam int CNT_W     = 3;

    localparam logic [PCT_W-1:0]  PCT_FULL      = 7'd100;
    localparam logic [DATA_W-1:0] DATA_MAX      = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] CFG_LEN_RESET = 32'd1000;
    localparam logic [CNT_W-1:0]  DIV_LAST      = CNT_W'(PCT_W - 1);

    localparam logic [MODE_W-1:0] MODE_UPDATE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AUTO_ON  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO_OFF = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TOGGLE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_EN   = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_TRIG    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PUMP    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ON_MS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFF_MS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ON_MM   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OFF_MM  = 3'd5;

    localparam int REL_L = 0;
    localparam int REL_C = 1;
    localparam int REL_R = 2;
    localparam int REL_P = 3;

    typedef struct packed {
        logic              trig_dist;
        logic              drive_pump;
        logic [DATA_W-1:0] on_ms;
        logic [DATA_W-1:0] off_ms;
        logic [DATA_W-1:0] on_mm;
        logic [DATA_W-1:0] off_mm;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul;
        logic div_step;
        logic prog_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_prog;
    } t_status;

    typedef struct packed {
        logic [3:0]       relays;
        logic             phase_on;
        logic             auto_active;
        logic [PCT_W-1:0] progress_pct;
    } t_result;

endpackage

// ===== hw/rtl/iocu_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocu_in_if
// event channel: mode, timestamp, odometer and sprayer enables
// ----------------------------------------------------------------------------
interface iocu_in_if;
    import iocu_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] now_ms;
    logic [DATA_W-1:0] total_distance_mm;
    logic              enable_left;
    logic              enable_center;
    logic              enable_right;

    modport source (
        output valid, mode, now_ms, total_distance_mm,
               enable_left, enable_center, enable_right,
        input  ready
    );
    modport sink (
        input  valid, mode, now_ms, total_distance_mm,
               enable_left, enable_center, enable_right,
        output ready
    );
endinterface

// ===== hw/rtl/iocu_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocu_out_if
// result channel: relay states, phase, auto flag and progress
// ----------------------------------------------------------------------------
interface iocu_out_if;
    import iocu_pkg::*;

    logic             valid;
    logic             ready;
    logic             relay_left;
    logic             relay_center;
    logic             relay_right;
    logic             relay_pump;
    logic             phase_on;
    logic             auto_active;
    logic [PCT_W-1:0] progress_pct;

    modport source (
        output valid, relay_left, relay_center, relay_right, relay_pump,
               phase_on, auto_active, progress_pct,
        input  ready
    );
    modport sink (
        input  valid, relay_left, relay_center, relay_right, relay_pump,
               phase_on, auto_active, progress_pct,
        output ready
    );
endinterface

// ===== hw/rtl/iocu_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocu_regs
// apb register file for trigger source, relay target and phase lengths
// ----------------------------------------------------------------------------
module iocu_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [iocu_pkg::ADDR_W-1:0] paddr,
    input  logic [iocu_pkg::DATA_W-1:0] pwdata,
    output logic [iocu_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output iocu_pkg::t_cfg            o_cfg
);
    import iocu_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_dist  <= 1'b0;
            r_cfg.drive_pump <= 1'b0;
            r_cfg.on_ms      <= CFG_LEN_RESET;
            r_cfg.off_ms     <= CFG_LEN_RESET;
            r_cfg.on_mm      <= CFG_LEN_RESET;
            r_cfg.off_mm     <= CFG_LEN_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TRIG:   r_cfg.trig_dist  <= pwdata[0];
                REG_PUMP:   r_cfg.drive_pump <= pwdata[0];
                REG_ON_MS:  r_cfg.on_ms      <= pwdata;
                REG_OFF_MS: r_cfg.off_ms     <= pwdata;
                REG_ON_MM:  r_cfg.on_mm      <= pwdata;
                REG_OFF_MM: r_cfg.off_mm     <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TRIG:   prdata = DATA_W'(r_cfg.trig_dist);
            REG_PUMP:   prdata = DATA_W'(r_cfg.drive_pump);
            REG_ON_MS:  prdata = r_cfg.on_ms;
            REG_OFF_MS: prdata = r_cfg.off_ms;
            REG_ON_MM:  prdata = r_cfg.on_mm;
            REG_OFF_MM: prdata = r_cfg.off_mm;
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/iocu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocu_ctrl
// sequencer: event execute, progress multiply, serial divide, result hand-off
// ----------------------------------------------------------------------------
module iocu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  iocu_pkg::t_status  i_status,
    output iocu_pkg::t_cmd     o_cmd
);
    import iocu_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_PROG = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_cmd             w_cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                w_cmd.exec = 1'b1;
                n_state    = i_status.need_prog ? S_MUL : S_DONE;
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_PROG;
                end
            end
            S_PROG: begin
                w_cmd.prog_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// ===== hw/rtl/iocu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iocu_dp
// cycle state, phase switching, relay drive and restoring percent divider
// ----------------------------------------------------------------------------
module iocu_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iocu_pkg::t_cmd                i_cmd,
    input  iocu_pkg::t_cfg                i_cfg,
    input  logic [iocu_pkg::MODE_W-1:0]   i_mode,
    input  logic [iocu_pkg::DATA_W-1:0]   i_now_ms,
    input  logic [iocu_pkg::DATA_W-1:0]   i_total_distance_mm,
    input  logic [2:0]                    i_enables,
    output iocu_pkg::t_status             o_status,
    output iocu_pkg::t_result             o_result
);
    import iocu_pkg::*;

    function automatic logic [3:0] drive(input logic [3:0] rel, input logic [2:0] en,
                                         input logic pump, input logic ph);
        logic [3:0] res;
        res = rel;
        if (!pump) begin
            if (en[0]) res[REL_L] = ph;
            if (en[1]) res[REL_C] = ph;
            if (en[2]) res[REL_R] = ph;
        end else begin
            res[REL_P] = ph;
        end
        return res;
    endfunction

    // latched event
    logic [MODE_W-1:0]    r_mode;
    logic [TIME_BITS-1:0] r_now;
    logic [DATA_W-1:0]    r_odo;
    logic [2:0]           r_en_in;

    // cycle state
    logic                 r_auto, n_auto;
    logic                 r_phase, n_phase;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [DATA_W-1:0]    r_last, n_last;
    logic [DATA_W-1:0]    r_acc, n_acc;
    logic [2:0]           r_en, n_en;
    logic [3:0]           r_relay, n_relay;
    logic [PCT_W-1:0]     r_prog;

    // progress unit
    logic [DATA_W-1:0]    r_val, n_val;
    logic [DATA_W-1:0]    r_tgt, n_tgt;
    logic [PROD_W-1:0]    r_rem;
    logic [PROD_W-1:0]    r_div;
    logic [PCT_W-1:0]     r_q;
    logic                 r_sat;
    t_result              r_out;

    logic [TIME_BITS-1:0] w_elapsed;
    logic [DATA_W-1:0]    w_tgt_ms, w_tgt_mm, w_delta;
    logic [DATA_W:0]      w_sum;
    logic [DATA_W-1:0]    w_sum_sat;
    logic                 w_set_on;
    logic                 w_ge;

    assign w_tgt_ms  = r_phase ? i_cfg.on_ms : i_cfg.off_ms;
    assign w_tgt_mm  = r_phase ? i_cfg.on_mm : i_cfg.off_mm;
    assign w_elapsed = r_now - r_start;
    assign w_delta   = r_odo - r_last;
    assign w_sum     = {1'b0, r_acc} + {1'b0, w_delta};
    assign w_sum_sat = w_sum[DATA_W] ? DATA_MAX : w_sum[DATA_W-1:0];
    assign w_set_on  = (r_mode == MODE_AUTO_ON) ? 1'b1 :
                       (r_mode == MODE_TOGGLE)  ? ~r_auto : 1'b0;

    always_comb begin
        n_auto  = r_auto;
        n_phase = r_phase;
        n_start = r_start;
        n_last  = r_last;
        n_acc   = r_acc;
        n_en    = r_en;
        n_relay = r_relay;
        n_val   = r_val;
        n_tgt   = r_tgt;
        w_ge    = 1'b0;
        unique case (r_mode)
            MODE_UPDATE: begin
                if (!r_auto) begin
                    if (r_phase) begin
                        n_phase = 1'b0;
                        n_relay = drive(r_relay, r_en, i_cfg.drive_pump, 1'b0);
                    end
                end else if (!i_cfg.trig_dist) begin
                    w_ge  = ELAP_W'(w_elapsed) >= ELAP_W'(w_tgt_ms);
                    n_tgt = w_tgt_ms;
                    if (w_ge) begin
                        n_start = r_now;
                        n_phase = ~r_phase;
                        n_relay = drive(r_relay, r_en, i_cfg.drive_pump, ~r_phase);
                        n_val   = '0;
                    end else begin
                        n_val = DATA_W'(w_elapsed);
                    end
                end else begin
                    w_ge   = w_sum_sat >= w_tgt_mm;
                    n_tgt  = w_tgt_mm;
                    n_last = r_odo;
                    if (w_ge) begin
                        n_acc   = '0;
                        n_phase = ~r_phase;
                        n_relay = drive(r_relay, r_en, i_cfg.drive_pump, ~r_phase);
                        n_val   = '0;
                    end else begin
                        n_acc = w_sum_sat;
                        n_val = w_sum_sat;
                    end
                end
            end
            MODE_AUTO_ON, MODE_AUTO_OFF, MODE_TOGGLE: begin
                n_auto = w_set_on;
                if (w_set_on) begin
                    n_start = r_now;
                    n_last  = r_odo;
                    n_acc   = '0;
                end
                n_phase = w_set_on;
                n_relay = drive(r_relay, r_en, i_cfg.drive_pump, w_set_on);
            end
            MODE_SET_EN: begin
                n_en = r_en_in;
                if (r_auto && !i_cfg.drive_pump) begin
                    n_relay[REL_L] = r_phase && r_en_in[0];
                    n_relay[REL_C] = r_phase && r_en_in[1];
                    n_relay[REL_R] = r_phase && r_en_in[2];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status.need_prog = (r_mode == MODE_UPDATE) && r_auto;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_now   <= TIME_BITS'(i_now_ms);
            r_odo   <= i_total_distance_mm;
            r_en_in <= i_enables;
        end
        if (i_cmd.exec) begin
            r_val <= n_val;
            r_tgt <= n_tgt;
        end
        if (i_cmd.mul) begin
            r_rem <= PROD_W'(r_val) * PROD_W'(PCT_FULL);
            r_div <= PROD_W'({r_tgt, {(PCT_W-1){1'b0}}});
            r_sat <= (r_tgt == '0) || (r_val >= r_tgt);
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_div) begin
                r_rem <= r_rem - r_div;
                r_q   <= {r_q[PCT_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[PCT_W-2:0], 1'b0};
            end
            r_div <= r_div >> 1;
        end
        if (i_cmd.out_load) begin
            r_out.relays       <= r_relay;
            r_out.phase_on     <= r_phase;
            r_out.auto_active  <= r_auto;
            r_out.progress_pct <= r_prog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto  <= 1'b0;
            r_phase <= 1'b0;
            r_start <= '0;
            r_last  <= '0;
            r_acc   <= '0;
            r_en    <= '0;
            r_relay <= '0;
            r_prog  <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_auto  <= n_auto;
                r_phase <= n_phase;
                r_start <= n_start;
                r_last  <= n_last;
                r_acc   <= n_acc;
                r_en    <= n_en;
                r_relay <= n_relay;
            end
            if (i_cmd.prog_wr) begin
                r_prog <= r_sat ? PCT_FULL : r_q;
            end
        end
    end

    assign o_result = r_out;

endmodule

// ===== hw/rtl/intermittent_on_off_cycler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intermittent_on_off_cycler_unit
// asymmetric on/off cycle timer, switching by time or by distance
// ----------------------------------------------------------------------------
// events enter on i_in (valid/ready); each event gives exactly one result
// beat on o_out. the user must write settings over the apb port only while
// idle; the block itself does not enforce it. one event at a time: ready is
// high only while the sequencer is idle. an update with auto cycling active
// passes execute, multiply by 100, seven divide steps of the restoring
// divider, progress write and hand-off before it reaches the result register;
// every other event passes only execute and hand-off.
// the result sits in an output register: the sequencer goes back to idle
// and takes the next event while that beat waits, and only stalls in its
// hand-off step when a second result is ready before the first is taken.
// synchronous active-low reset clears the cycle state, relays and progress,
// loads the settings defaults (time trigger, sprayer relays, 1000 ms and
// 1000 mm for both phases) and empties the output register.
// ----------------------------------------------------------------------------
module intermittent_on_off_cycler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    iocu_in_if.sink                       i_in,
    iocu_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iocu_pkg::ADDR_W-1:0]   paddr,
    input  logic [iocu_pkg::DATA_W-1:0]   pwdata,
    output logic [iocu_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import iocu_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;
    logic    w_in_ready;
    logic    w_out_valid;

    iocu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    iocu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    iocu_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_cfg               (w_cfg),
        .i_mode              (i_in.mode),
        .i_now_ms            (i_in.now_ms),
        .i_total_distance_mm (i_in.total_distance_mm),
        .i_enables           ({i_in.enable_right, i_in.enable_center, i_in.enable_left}),
        .o_status            (w_status),
        .o_result            (w_result)
    );

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = w_out_valid;
    assign o_out.relay_left   = w_result.relays[REL_L];
    assign o_out.relay_center = w_result.relays[REL_C];
    assign o_out.relay_right  = w_result.relays[REL_R];
    assign o_out.relay_pump   = w_result.relays[REL_P];
    assign o_out.phase_on     = w_result.phase_on;
    assign o_out.auto_active  = w_result.auto_active;
    assign o_out.progress_pct = w_result.progress_pct;

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.progress_pct <= PCT_FULL))
        else $error("progress above full scale");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("event accepted while previous one in flight");

    a_phase_needs_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.auto_active) |-> !o_out.phase_on)
        else $error("on phase reported with auto cycling off");

    a_load_into_free_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten before taken");

endmodule

// ===== tb/sv/tb_intermittent_on_off_cycler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_intermittent_on_off_cycler_unit
// self-checking bench for the on/off cycler: events go in over a valid/ready
// channel, each result beat is checked against an in-bench cycler model that
// tracks phase, relays, auto flag and progress. settings are written over the
// apb port between phases while the block is idle. directed events cover the
// time and distance corner cases, then random phases with random settings,
// random gaps on both sides and a long result hold-off.
// ----------------------------------------------------------------------------
module tb_intermittent_on_off_cycler_unit;
    import iocu_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] now_ms;
        logic [DATA_W-1:0] odo_mm;
        logic [2:0]        en;
    } t_spray_event;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    iocu_in_if  ev_if();
    iocu_out_if res_if();

    intermittent_on_off_cycler_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // settings copy
    logic              cfg_dist;
    logic              cfg_pump;
    logic [DATA_W-1:0] cfg_on_ms;
    logic [DATA_W-1:0] cfg_off_ms;
    logic [DATA_W-1:0] cfg_on_mm;
    logic [DATA_W-1:0] cfg_off_mm;

    // cycler state copy
    logic                 cyc_auto;
    logic                 cyc_phase;
    logic [TIME_BITS-1:0] cyc_start_ms;
    logic [DATA_W-1:0]    cyc_last_mm;
    logic [DATA_W-1:0]    cyc_acc_mm;
    logic [2:0]           cyc_en;
    logic [3:0]           cyc_relays;
    logic [PCT_W-1:0]     cyc_pct;

    t_result expected_status_q[$];

    int err_count = 0;
    int cycle_count = 0;
    bit no_idle = 0;
    int hold_req = 0;

    logic [DATA_W-1:0] cur_ms;
    logic [DATA_W-1:0] cur_mm;
    int step_ms_max;
    int step_mm_max;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PCT_W-1:0] pct_of(logic [63:0] value, logic [63:0] target);
        if (target == 0 || value >= target) return PCT_FULL;
        return PCT_W'((value * 64'd100) / target);
    endfunction

    task automatic drive_relays();
        if (!cfg_pump) begin
            for (int i = 0; i < 3; i++)
                if (cyc_en[i]) cyc_relays[i] = cyc_phase;
        end else begin
            cyc_relays[REL_P] = cyc_phase;
        end
    endtask

    task automatic switch_auto(input logic on, input t_spray_event ev);
        cyc_auto = on;
        if (!on) begin
            cyc_phase = 1'b0;
        end else begin
            cyc_start_ms = TIME_BITS'(ev.now_ms);
            cyc_last_mm  = ev.odo_mm;
            cyc_acc_mm   = '0;
            cyc_phase    = 1'b1;
        end
        drive_relays();
    endtask

    task automatic advance_cycler(input t_spray_event ev);
        logic [TIME_BITS-1:0] elapsed;
        logic [DATA_W-1:0]    target;
        logic [DATA_W-1:0]    sum;
        t_result              res;
        case (ev.mode)
            MODE_UPDATE: begin
                if (!cyc_auto) begin
                    if (cyc_phase) begin
                        cyc_phase = 1'b0;
                        drive_relays();
                    end
                end else if (!cfg_dist) begin
                    target  = cyc_phase ? cfg_on_ms : cfg_off_ms;
                    elapsed = TIME_BITS'(ev.now_ms) - cyc_start_ms;
                    if (64'(elapsed) >= 64'(target)) begin
                        cyc_start_ms = TIME_BITS'(ev.now_ms);
                        cyc_phase    = ~cyc_phase;
                        drive_relays();
                        elapsed = '0;
                    end
                    cyc_pct = pct_of(64'(elapsed), 64'(target));
                end else begin
                    target      = cyc_phase ? cfg_on_mm : cfg_off_mm;
                    sum         = cyc_acc_mm + (ev.odo_mm - cyc_last_mm);
                    cyc_last_mm = ev.odo_mm;
                    if (sum < cyc_acc_mm) sum = DATA_MAX;
                    cyc_acc_mm = sum;
                    if (cyc_acc_mm >= target) begin
                        cyc_acc_mm = '0;
                        cyc_phase  = ~cyc_phase;
                        drive_relays();
                    end
                    cyc_pct = pct_of(64'(cyc_acc_mm), 64'(target));
                end
            end
            MODE_AUTO_ON:  switch_auto(1'b1, ev);
            MODE_AUTO_OFF: switch_auto(1'b0, ev);
            MODE_TOGGLE:   switch_auto(~cyc_auto, ev);
            MODE_SET_EN: begin
                cyc_en = ev.en;
                if (cyc_auto && !cfg_pump) begin
                    for (int i = 0; i < 3; i++)
                        cyc_relays[i] = cyc_phase & cyc_en[i];
                end
            end
            default: ;
        endcase
        res.relays       = cyc_relays;
        res.phase_on     = cyc_phase;
        res.auto_active  = cyc_auto;
        res.progress_pct = cyc_pct;
        expected_status_q.push_back(res);
    endtask

    task automatic send_event(input t_spray_event ev);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev_if.valid             <= 1'b1;
        ev_if.mode              <= ev.mode;
        ev_if.now_ms            <= ev.now_ms;
        ev_if.total_distance_mm <= ev.odo_mm;
        ev_if.enable_left       <= ev.en[0];
        ev_if.enable_center     <= ev.en[1];
        ev_if.enable_right      <= ev.en[2];
        do @(posedge i_clk); while (!ev_if.ready);
        advance_cycler(ev);
    endtask

    task automatic send_at(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] now_ms,
                           input logic [DATA_W-1:0] odo_mm, input logic [2:0] en);
        t_spray_event ev;
        ev.mode   = mode;
        ev.now_ms = now_ms;
        ev.odo_mm = odo_mm;
        ev.en     = en;
        send_event(ev);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_TRIG:   cfg_dist   = val[0];
            REG_PUMP:   cfg_pump   = val[0];
            REG_ON_MS:  cfg_on_ms  = val;
            REG_OFF_MS: cfg_off_ms = val;
            REG_ON_MM:  cfg_on_mm  = val;
            REG_OFF_MM: cfg_off_mm = val;
            default: ;
        endcase
    endtask

    task automatic drain_cycler();
        ev_if.valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [PCT_W-1:0] want,
                                 input logic [PCT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t: result beat expected none actual relays %b%b%b%b pct %0d",
                         $time, res_if.relay_pump, res_if.relay_right, res_if.relay_center,
                         res_if.relay_left, res_if.progress_pct);
                err_count++;
            end else begin
                want = expected_status_q.pop_front();
                compare_field("relay_left",   PCT_W'(want.relays[REL_L]),
                              PCT_W'(res_if.relay_left));
                compare_field("relay_center", PCT_W'(want.relays[REL_C]),
                              PCT_W'(res_if.relay_center));
                compare_field("relay_right",  PCT_W'(want.relays[REL_R]),
                              PCT_W'(res_if.relay_right));
                compare_field("relay_pump",   PCT_W'(want.relays[REL_P]),
                              PCT_W'(res_if.relay_pump));
                compare_field("phase_on",     PCT_W'(want.phase_on),
                              PCT_W'(res_if.phase_on));
                compare_field("auto_active",  PCT_W'(want.auto_active),
                              PCT_W'(res_if.auto_active));
                compare_field("progress_pct", want.progress_pct, res_if.progress_pct);
            end
        end
    end

    // result side: random stalls, optional long hold-off
    initial begin
        int seg;
        int hold_left;
        logic level;
        seg       = 0;
        hold_left = 0;
        level     = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req <= 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (no_idle) begin
                res_if.ready <= 1'b1;
            end else begin
                if (seg == 0) begin
                    seg = level ? pick_gap() : 0;
                    if (seg > 0) begin
                        level = 1'b0;
                    end else begin
                        level = 1'b1;
                        seg   = $urandom_range(1, 16);
                    end
                end
                seg--;
                res_if.ready <= level;
            end
        end
    end

    task automatic make_event(input logic [MODE_W-1:0] mode, output t_spray_event ev);
        if ($urandom_range(0, 99) < 4) begin
            cur_ms = $urandom;
            cur_mm = $urandom;
        end else begin
            cur_ms = cur_ms + DATA_W'($urandom_range(0, step_ms_max));
            cur_mm = cur_mm + DATA_W'($urandom_range(0, step_mm_max));
        end
        ev.mode   = mode;
        ev.now_ms = cur_ms;
        ev.odo_mm = cur_mm;
        ev.en     = 3'($urandom_range(0, 7));
    endtask

    task automatic run_random_events(input int count);
        t_spray_event ev;
        logic [MODE_W-1:0] mode;
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60)      mode = MODE_UPDATE;
            else if (r < 68) mode = MODE_AUTO_ON;
            else if (r < 73) mode = MODE_AUTO_OFF;
            else if (r < 80) mode = MODE_TOGGLE;
            else if (r < 92) mode = MODE_SET_EN;
            else             mode = MODE_W'($urandom_range(5, 7));
            make_event(mode, ev);
            send_event(ev);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 14) return DATA_MAX;
        if (r < 20) return $urandom;
        return DATA_W'($urandom_range(1, 60));
    endfunction

    task automatic test_time_directed();
        send_at(MODE_UPDATE,   32'd0,          32'd0, 3'b000);
        send_at(3'd5,          32'd0,          32'd0, 3'b111);
        send_at(3'd7,          32'hFFFF_FFFF,  32'hFFFF_FFFF, 3'b111);
        send_at(MODE_SET_EN,   32'd0,          32'd0, 3'b111);
        send_at(MODE_AUTO_ON,  32'd0,          32'd0, 3'b000);
        send_at(MODE_UPDATE,   32'd500,        32'd0, 3'b000);
        send_at(MODE_UPDATE,   32'd1000,       32'd0, 3'b000);
        send_at(MODE_UPDATE,   32'd1999,       32'd0, 3'b000);
        send_at(MODE_TOGGLE,   32'd2000,       32'd0, 3'b000);
        send_at(MODE_UPDATE,   32'd2500,       32'd0, 3'b000);
        send_at(MODE_TOGGLE,   32'd3000,       32'd0, 3'b000);
        send_at(MODE_SET_EN,   32'd3100,       32'd0, 3'b101);
        send_at(MODE_AUTO_ON,  32'hFFFF_FF00,  32'd0, 3'b000);
        send_at(MODE_UPDATE,   32'h0000_0100,  32'd0, 3'b000);
        send_at(MODE_AUTO_OFF, 32'h0000_0200,  32'd0, 3'b000);
        drain_cycler();
        // zero on interval, full-scale off interval, pump relay
        write_reg(REG_PUMP,   32'd1);
        write_reg(REG_ON_MS,  32'd0);
        write_reg(REG_OFF_MS, DATA_MAX);
        send_at(MODE_AUTO_ON, 32'd5, 32'd0, 3'b000);
        send_at(MODE_UPDATE,  32'd5, 32'd0, 3'b000);
        send_at(MODE_UPDATE,  32'd6, 32'd0, 3'b000);
        send_at(MODE_UPDATE,  32'd4, 32'd0, 3'b000);
        drain_cycler();
    endtask

    task automatic test_distance_directed();
        write_reg(REG_TRIG,   32'd1);
        write_reg(REG_PUMP,   32'd0);
        write_reg(REG_ON_MM,  DATA_MAX);
        write_reg(REG_OFF_MM, 32'd0);
        send_at(MODE_SET_EN,  32'd0, 32'd100,        3'b111);
        send_at(MODE_AUTO_ON, 32'd0, 32'd100,        3'b000);
        send_at(MODE_UPDATE,  32'd0, 32'hF000_0064,  3'b000);
        // accumulator saturates and reaches the full-scale target
        send_at(MODE_UPDATE,  32'd0, 32'hE000_0064,  3'b000);
        send_at(MODE_UPDATE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b000);
        send_at(MODE_UPDATE,  32'd0, 32'hFFFF_FFFF,  3'b000);
        drain_cycler();
    endtask

    task automatic test_random_settings();
        logic [DATA_W-1:0] val;
        for (int ph = 0; ph < 7; ph++) begin
            no_idle = (ph == 3);
            val = $urandom;
            val[0] = ph[0];
            write_reg(REG_TRIG, val);
            val = $urandom;
            val[0] = ph[1];
            write_reg(REG_PUMP, val);
            write_reg(REG_ON_MS,  pick_length());
            write_reg(REG_OFF_MS, pick_length());
            write_reg(REG_ON_MM,  pick_length());
            write_reg(REG_OFF_MM, pick_length());
            step_ms_max = $urandom_range(1, 30);
            step_mm_max = $urandom_range(1, 30);
            run_random_events(85);
            drain_cycler();
        end
        no_idle = 0;
    endtask

    task automatic test_backpressure();
        write_reg(REG_TRIG,   32'd0);
        write_reg(REG_ON_MS,  32'd7);
        write_reg(REG_OFF_MS, 32'd3);
        step_ms_max = 4;
        no_idle = 1;
        send_at(MODE_AUTO_ON, cur_ms, cur_mm, 3'b000);
        hold_req <= 300;
        run_random_events(40);
        drain_cycler();
        no_idle = 0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        ev_if.valid             <= 1'b0;
        ev_if.mode              <= MODE_UPDATE;
        ev_if.now_ms            <= '0;
        ev_if.total_distance_mm <= '0;
        ev_if.enable_left       <= 1'b0;
        ev_if.enable_center     <= 1'b0;
        ev_if.enable_right      <= 1'b0;

        cfg_dist   = 1'b0;
        cfg_pump   = 1'b0;
        cfg_on_ms  = CFG_LEN_RESET;
        cfg_off_ms = CFG_LEN_RESET;
        cfg_on_mm  = CFG_LEN_RESET;
        cfg_off_mm = CFG_LEN_RESET;
        cyc_auto     = 1'b0;
        cyc_phase    = 1'b0;
        cyc_start_ms = '0;
        cyc_last_mm  = '0;
        cyc_acc_mm   = '0;
        cyc_en       = '0;
        cyc_relays   = '0;
        cyc_pct      = '0;
        cur_ms = '0;
        cur_mm = '0;
        step_ms_max = 10;
        step_mm_max = 10;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_time_directed();
        test_distance_directed();
        test_random_settings();
        test_backpressure();

        drain_cycler();
        if (err_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== intermittent_on_off_cycler_unit.f =====
hw/rtl/iocu_pkg.sv
hw/rtl/iocu_in_if.sv
hw/rtl/iocu_out_if.sv
hw/rtl/iocu_regs.sv
hw/rtl/iocu_ctrl.sv
hw/rtl/iocu_dp.sv
hw/rtl/intermittent_on_off_cycler_unit.sv
tb/sv/tb_intermittent_on_off_cycler_unit.sv
